@@ hw/rtl/vertex_triple_dedup_table_defines.svh @@
// Shared assertion macros for the vertex deduplication block.
`ifndef VERTEX_TRIPLE_DEDUP_TABLE_DEFINES_SVH
`define VERTEX_TRIPLE_DEDUP_TABLE_DEFINES_SVH

// Plain property that must hold at every sampled clock edge outside reset.
`define VTD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define VTD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/vtd_pkg.sv @@
`timescale 1ns / 1ps

package vtd_pkg;

  // Field widths of one corner and of one result.
  localparam int IDX_W  = 20;
  localparam int KEY_W  = 3 * IDX_W;
  localparam int VNUM_W = 8;

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One classified request: the mesh restart flag and the packed triple.
  typedef struct packed {
    logic             first_of_mesh;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef logic [VNUM_W-1:0] vnum_t;

endpackage

@@ hw/rtl/vtd_in_if.sv @@
`timescale 1ns / 1ps

interface vtd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      first_of_mesh;
  logic [vtd_pkg::IDX_W-1:0] position_index;
  logic [vtd_pkg::IDX_W-1:0] texture_index;
  logic [vtd_pkg::IDX_W-1:0] normal_index;

  modport source (
    output valid, first_of_mesh, position_index, texture_index, normal_index,
    input  ready
  );

  modport sink (
    input  valid, first_of_mesh, position_index, texture_index, normal_index,
    output ready
  );
endinterface

@@ hw/rtl/vtd_out_if.sv @@
`timescale 1ns / 1ps

interface vtd_out_if;
  logic                       valid;
  logic                       ready;
  logic [vtd_pkg::VNUM_W-1:0] vertex_number;
  logic                       is_new;
  logic                       table_full;

  modport source (
    output valid, vertex_number, is_new, table_full,
    input  ready
  );

  modport sink (
    input  valid, vertex_number, is_new, table_full,
    output ready
  );
endinterface

@@ hw/rtl/vtd_ram.sv @@
`timescale 1ns / 1ps

module vtd_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/vtd_front.sv @@
`timescale 1ns / 1ps

module vtd_front (
  input  logic          clk,
  input  logic          rst_n,
  vtd_in_if.sink        in_if,
  output logic          req_valid,
  input  logic          req_ready,
  output vtd_pkg::req_t req
);

  vtd_pkg::req_t                 q_r [vtd_pkg::QUEUE_DEPTH];
  logic [vtd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [vtd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [vtd_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                          push;
  logic                          pop;
  vtd_pkg::req_t                 in_req;

  // Pack the three indices into one key and keep the restart flag beside it.
  always_comb begin
    in_req.first_of_mesh = in_if.first_of_mesh;
    in_req.key = {in_if.position_index, in_if.texture_index, in_if.normal_index};
  end

  // Queue handshakes on both sides.
  assign in_if.ready = (count_r != vtd_pkg::QCNT_W'(vtd_pkg::QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign req_valid   = (count_r != '0);
  assign pop         = req_valid && req_ready;
  assign req         = q_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

@@ hw/rtl/vtd_back.sv @@
`timescale 1ns / 1ps

module vtd_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  vtd_pkg::req_t req,
  vtd_out_if.source     out_if
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SEARCH  = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               used_r, used_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [vtd_pkg::KEY_W-1:0]   key_r, key_nxt;
  vtd_pkg::vnum_t              res_vnum_r, res_vnum_nxt;
  logic                        res_new_r, res_new_nxt;
  logic                        res_full_r, res_full_nxt;
  logic                        out_valid_r, out_valid_nxt;
  vtd_pkg::vnum_t              out_vnum_r;
  logic                        out_new_r;
  logic                        out_full_r;
  logic                        out_load;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [vtd_pkg::KEY_W-1:0]   ram_rdata;

  vtd_ram #(
    .WIDTH (vtd_pkg::KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state_r == ST_IDLE);
  assign ram_waddr = used_r[AW-1:0];

  // Sequencer: restart, linear search one entry per cycle, append (or refuse when full), emit.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    res_vnum_nxt  = res_vnum_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          key_nxt = req.key;
          idx_nxt = '0;
          if (req.first_of_mesh) begin
            used_nxt = '0;
          end
          if (req.first_of_mesh || (used_r == '0)) begin
            state_nxt = ST_RESOLVE;
          end else begin
            ram_re    = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (ram_rdata == key_r) begin
          res_vnum_nxt = vtd_pkg::VNUM_W'(idx_r);
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = ST_EMIT;
        end else if (CW'(idx_r) + CW'(1) == used_r) begin
          state_nxt = ST_RESOLVE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(1);
        end
      end

      ST_RESOLVE: begin
        if (used_r >= CW'(TABLE_DEPTH)) begin
          res_vnum_nxt = '0;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b1;
        end else begin
          ram_we       = 1'b1;
          res_vnum_nxt = vtd_pkg::VNUM_W'(used_r[AW-1:0]);
          res_new_nxt  = 1'b1;
          res_full_nxt = 1'b0;
          used_nxt     = used_r + CW'(1);
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working payload of the current request and the held result.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    res_vnum_r <= res_vnum_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    if (out_load) begin
      out_vnum_r <= res_vnum_r;
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.vertex_number = out_vnum_r;
  assign out_if.is_new        = out_new_r;
  assign out_if.table_full    = out_full_r;

endmodule

@@ hw/rtl/vertex_triple_dedup_table.sv @@
`timescale 1ns / 1ps
// A corner is queued by the front; the back then searches the stored entries in order and
// emits the index of the matching entry, or appends the triple when none matches, or
// refuses it when the table is full. A first-of-mesh corner empties the table and is
// stored without a search. The back takes the next corner only after the last result is
// loaded into the output register; the search reads one entry per cycle from the store.
// Reset (synchronous, active low) empties the queue and the table count; the store is not swept.

module vertex_triple_dedup_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  vtd_in_if.sink     in_if,
  vtd_out_if.source  out_if
);

  logic          req_valid;
  logic          req_ready;
  vtd_pkg::req_t req;

  // Front: accept corners, pack the triple and queue the request.
  vtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  // Back: search the table, append new triples and hold the result.
  vtd_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_if    (out_if)
  );

endmodule

@@ hw/rtl/vtd_checker.sv @@
`timescale 1ns / 1ps
`include "vertex_triple_dedup_table_defines.svh"

module vtd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vtd_pkg::VNUM_W-1:0] out_vertex_number,
  input logic                       out_is_new,
  input logic                       out_table_full
);

  // A stalled result stays offered.
  `VTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A full-table result never claims to be new.
  `VTD_ASSERT_IMPL(a_full_not_new, clk, rst_n, out_valid, !(out_is_new && out_table_full), "new and full together")

  // A full-table result carries vertex zero.
  `VTD_ASSERT_IMPL(a_full_zero, clk, rst_n, out_valid && out_table_full, out_vertex_number == '0, "full result with nonzero vertex")

  // Known control after reset.
  `VTD_ASSERT(a_valid_known, clk, rst_n, !$isunknown(out_valid), "result valid is unknown")

endmodule

bind vertex_triple_dedup_table vtd_checker u_vtd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_vertex_number (out_if.vertex_number),
  .out_is_new        (out_if.is_new),
  .out_table_full    (out_if.table_full)
);
